>>> design/ptrs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ptrs_pkg
// Shared types and constants for the periodic task release scheduler.
// ----------------------------------------------------------------------------
package ptrs_pkg;

  localparam int NUM_SLOTS = 8;  // task slots, 1 to 256
  localparam int MASK_W    = 8;  // slots visible in release_mask

  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 16;

  localparam logic [8:0] NUM_SLOTS_W9 = 9'(NUM_SLOTS);

  localparam logic [2:0] OP_TICK    = 3'd0;
  localparam logic [2:0] OP_CREATE  = 3'd1;
  localparam logic [2:0] OP_DELETE  = 3'd2;
  localparam logic [2:0] OP_SUSPEND = 3'd3;
  localparam logic [2:0] OP_RESUME  = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_RANGE    = 2'd1;
  localparam logic [1:0] ST_OCCUPIED = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  typedef struct packed {
    logic [7:0] first_delay;
    logic [7:0] period;
    logic [7:0] slot;
    logic [2:0] opcode;
  } ptrs_item_t;

  typedef struct packed {
    logic [MASK_W-1:0] release_mask;
    logic [1:0]        status;
  } ptrs_result_t;

endpackage : ptrs_pkg
`default_nettype wire

>>> design/ptrs_slot_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ptrs_slot_table
// Task slot state and the combinational operation logic (tick, create,
// delete, suspend, resume). Result is combinational from the held item.
// ----------------------------------------------------------------------------
module ptrs_slot_table
  import ptrs_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         fire,    // commit this item's state change
  input  wire ptrs_item_t   item,
  output ptrs_result_t      result
);

  logic [NUM_SLOTS-1:0] used_r, used_nxt;
  logic [NUM_SLOTS-1:0] ready_r, ready_nxt;
  logic [7:0]           cnt_r [NUM_SLOTS];
  logic [7:0]           cnt_nxt [NUM_SLOTS];
  logic [7:0]           rld_r [NUM_SLOTS];
  logic [7:0]           rld_nxt [NUM_SLOTS];

  logic [NUM_SLOTS-1:0] sel;
  logic [NUM_SLOTS-1:0] rel;
  logic [MASK_W-1:0]    mask;
  logic                 is_tick, is_table_op, in_range, hit_used;
  logic                 do_create, do_delete, do_suspend, do_resume;
  logic [1:0]           status;
  logic [7:0]           reload;

  assign is_tick     = (item.opcode == OP_TICK);
  assign is_table_op = (item.opcode == OP_CREATE) || (item.opcode == OP_DELETE) ||
                       (item.opcode == OP_SUSPEND) || (item.opcode == OP_RESUME);
  assign in_range    = ({1'b0, item.slot} < NUM_SLOTS_W9);
  assign hit_used    = |(used_r & sel);
  assign reload      = item.period - 8'd1;

  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      sel[i] = (item.slot == 8'(i));
    end
  end

  always_comb begin
    status = ST_OK;
    if (is_table_op) begin
      if (!in_range) begin
        status = ST_RANGE;
      end else if (item.opcode == OP_CREATE) begin
        status = hit_used ? ST_OCCUPIED : ST_OK;
      end else begin
        status = hit_used ? ST_OK : ST_EMPTY;
      end
    end
  end

  assign do_create  = is_table_op && in_range && (item.opcode == OP_CREATE) && !hit_used;
  assign do_delete  = is_table_op && in_range && (item.opcode == OP_DELETE) && hit_used;
  assign do_suspend = is_table_op && in_range && (item.opcode == OP_SUSPEND) && hit_used;
  assign do_resume  = is_table_op && in_range && (item.opcode == OP_RESUME) && hit_used;

  always_comb begin
    used_nxt  = used_r;
    ready_nxt = ready_r;
    rel       = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      cnt_nxt[i] = cnt_r[i];
      rld_nxt[i] = rld_r[i];
      if (is_tick) begin
        if (used_r[i] && ready_r[i]) begin
          if (cnt_r[i] == 8'd0) begin
            rel[i]     = 1'b1;
            cnt_nxt[i] = rld_r[i];
          end else begin
            cnt_nxt[i] = cnt_r[i] - 8'd1;
          end
        end
      end else if (sel[i]) begin
        if (do_create) begin
          used_nxt[i]  = 1'b1;
          ready_nxt[i] = 1'b1;
          cnt_nxt[i]   = item.first_delay;
          rld_nxt[i]   = reload;
        end else if (do_delete) begin
          // count/reload are dead while unused; create rewrites both
          used_nxt[i]  = 1'b0;
          ready_nxt[i] = 1'b0;
        end else if (do_suspend) begin
          ready_nxt[i] = 1'b0;
        end else if (do_resume) begin
          ready_nxt[i] = 1'b1;
        end
      end
    end
  end

  // slots past the mask width still run, they just have no mask bit
  for (genvar g = 0; g < MASK_W; g++) begin : g_mask
    if (g < NUM_SLOTS) begin : g_bit
      assign mask[g] = rel[g];
    end else begin : g_zero
      assign mask[g] = 1'b0;
    end
  end

  assign result.status       = status;
  assign result.release_mask = mask;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r  <= '0;
      ready_r <= '0;
    end else if (fire) begin
      used_r  <= used_nxt;
      ready_r <= ready_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        cnt_r[i] <= cnt_nxt[i];
        rld_r[i] <= rld_nxt[i];
      end
    end
  end

endmodule : ptrs_slot_table
`default_nettype wire

>>> design/periodic_task_release_scheduler.sv
`default_nettype none
// ----------------------------------------------------------------------------
// periodic_task_release_scheduler
// Slot table of periodic tasks: create/delete/suspend/resume and a tick
// that releases expired slots and reloads their countdowns.
// ----------------------------------------------------------------------------
// Pipeline: input register, then result register.
// Throughput: one beat per cycle unless out_tready stalls; all slots update in
//   parallel on a tick, table ops touch one slot, all in one logic pass between regs.
// Reset: synchronous, active low; empties all slots and drops held beats.
// ----------------------------------------------------------------------------
module periodic_task_release_scheduler
  import ptrs_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,

  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // [2:0] opcode, [10:3] slot, [18:11] period, [26:19] first_delay, rest zero
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,

  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // [1:0] status, [9:2] release_mask, rest zero
  output logic [OUT_TDATA_W-1:0]      out_tdata
);

  localparam int ITEM_W = $bits(ptrs_item_t);
  localparam int RES_W  = $bits(ptrs_result_t);

  // input stage
  logic         in_vld_r;
  ptrs_item_t   in_item_r;

  // result stage
  logic         out_vld_r;
  ptrs_result_t out_res_r;

  ptrs_result_t res;
  logic         out_free;
  logic         fire;

  // result slot frees when empty or being drained this cycle
  assign out_free  = !out_vld_r || out_tready;
  assign fire      = in_vld_r && out_free;
  assign in_tready = !in_vld_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_item_r <= ptrs_item_t'(in_tdata[ITEM_W-1:0]);
    end
  end

  ptrs_slot_table u_table (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .item   (in_item_r),
    .result (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(OUT_TDATA_W-RES_W){1'b0}}, out_res_r};

endmodule : periodic_task_release_scheduler
`default_nettype wire

>>> test/tb_periodic_task_release_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_periodic_task_release_scheduler
// Self-checking bench for the periodic task release scheduler. A scoreboard
// class keeps its own copy of the slot table, predicts status and release
// mask for every accepted input beat and checks result beats in order.
// Stimulus is a directed opening followed by random table traffic, with
// random idling on both streams and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_periodic_task_release_scheduler
  import ptrs_pkg::*;
;

  localparam int NUM_RANDOM     = 930;
  localparam int HOLD_CYCLES    = 120;   // long output hold-off
  localparam int HOLD_AT_ITEM   = 300;
  localparam int CALM_FIRST     = 500;   // no idling on either side in here
  localparam int CALM_LAST      = 650;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 10;

  // Scoreboard: slot table shadow plus queue of pending results.
  class release_scoreboard;
    bit                slot_used   [NUM_SLOTS];
    bit                slot_ready  [NUM_SLOTS];
    bit [7:0]          countdown   [NUM_SLOTS];
    bit [7:0]          reload_value[NUM_SLOTS];
    ptrs_result_t      pending_results[$];
    int                mismatches;

    function new();
      mismatches = 0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_used[i]    = 1'b0;
        slot_ready[i]   = 1'b0;
        countdown[i]    = '0;
        reload_value[i] = '0;
      end
    endfunction

    // Applies one command to the shadow table, returns its result.
    function ptrs_result_t apply_command(ptrs_item_t cmd);
      ptrs_result_t res;
      int           k;
      res = '0;
      res.status = ST_OK;
      k = cmd.slot;
      if (cmd.opcode == OP_TICK) begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (slot_used[i] && slot_ready[i]) begin
            if (countdown[i] == 8'd0) begin
              countdown[i] = reload_value[i];
              if (i < MASK_W) res.release_mask[i] = 1'b1;
            end else begin
              countdown[i] = countdown[i] - 8'd1;
            end
          end
        end
      end else if (cmd.opcode == OP_CREATE || cmd.opcode == OP_DELETE ||
                   cmd.opcode == OP_SUSPEND || cmd.opcode == OP_RESUME) begin
        if (k >= NUM_SLOTS) begin
          res.status = ST_RANGE;
        end else if (cmd.opcode == OP_CREATE) begin
          if (slot_used[k]) begin
            res.status = ST_OCCUPIED;
          end else begin
            slot_used[k]    = 1'b1;
            slot_ready[k]   = 1'b1;
            countdown[k]    = cmd.first_delay;
            reload_value[k] = cmd.period - 8'd1;  // period 0 wraps to 255
          end
        end else if (!slot_used[k]) begin
          res.status = ST_EMPTY;
        end else if (cmd.opcode == OP_DELETE) begin
          slot_used[k]    = 1'b0;
          slot_ready[k]   = 1'b0;
          countdown[k]    = '0;
          reload_value[k] = '0;
        end else if (cmd.opcode == OP_SUSPEND) begin
          slot_ready[k] = 1'b0;
        end else begin
          slot_ready[k] = 1'b1;
        end
      end
      // unknown opcodes fall through: no change, status ok, empty mask
      return res;
    endfunction

    function void note_command(ptrs_item_t cmd);
      pending_results.push_back(apply_command(cmd));
    endfunction

    function void check_result(ptrs_result_t got);
      ptrs_result_t exp;
      if (pending_results.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result beat: status %0d mask %02h",
                   got.status, got.release_mask);
        mismatches++;
      end else begin
        exp = pending_results.pop_front();
        if (got.status !== exp.status || got.release_mask !== exp.release_mask) begin
          if (mismatches < 10)
            $display("result mismatch: expected status %0d mask %02h, got status %0d mask %02h",
                     exp.status, exp.release_mask, got.status, got.release_mask);
          mismatches++;
        end
      end
    endfunction

    function int pending();
      return pending_results.size();
    endfunction
  endclass

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;   // opcode, slot, period, first_delay
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;         // status, release_mask

  release_scoreboard sb;
  bit                no_idle   = 1'b0;
  bit                hold_req  = 1'b0;
  int                idle_cycles = 0;

  always #5 clk = ~clk;

  periodic_task_release_scheduler dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Beat monitor and watchdog; inputs only change in the NBA region,
  // so values read here are the ones seen at the edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        sb.note_command(ptrs_item_t'(in_tdata[$bits(ptrs_item_t)-1:0]));
      if (out_tvalid && out_tready)
        sb.check_result(ptrs_result_t'(out_tdata[$bits(ptrs_result_t)-1:0]));
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("periodic_task_release_scheduler regression: fail");
          $finish;
        end
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_tready <= rst_n && (no_idle || $urandom_range(99) >= 34);
    end
  end

  function automatic ptrs_item_t make_cmd(logic [2:0] op, logic [7:0] slot,
                                          logic [7:0] period, logic [7:0] fd);
    ptrs_item_t c;
    c.opcode      = op;
    c.slot        = slot;
    c.period      = period;
    c.first_delay = fd;
    return c;
  endfunction

  // Mostly valid slots and short periods so releases happen often.
  function automatic ptrs_item_t random_cmd();
    int         pick;
    ptrs_item_t c;
    pick = $urandom_range(99);
    if (pick < 45)      c.opcode = OP_TICK;
    else if (pick < 67) c.opcode = OP_CREATE;
    else if (pick < 76) c.opcode = OP_DELETE;
    else if (pick < 86) c.opcode = OP_SUSPEND;
    else if (pick < 96) c.opcode = OP_RESUME;
    else                c.opcode = 3'($urandom_range(7, 5));
    c.slot        = ($urandom_range(9) == 0) ? 8'($urandom_range(255, NUM_SLOTS))
                                             : 8'($urandom_range(NUM_SLOTS - 1));
    c.period      = ($urandom_range(4) == 0) ? 8'($urandom) : 8'($urandom_range(6));
    c.first_delay = ($urandom_range(4) == 0) ? 8'($urandom) : 8'($urandom_range(5));
    return c;
  endfunction

  // Drives one beat; returns at the edge where it was taken.
  task automatic send_command(ptrs_item_t cmd);
    while (!no_idle && $urandom_range(99) < 34) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_TDATA_W'(cmd);
    do @(posedge clk); while (!in_tready);
  endtask

  initial begin
    ptrs_item_t directed[$];
    int         sent;
    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed opening: empty tick, both period extremes, error statuses,
    // idempotent suspend/resume, unknown opcodes, deletes
    directed.push_back(make_cmd(OP_TICK,    8'd0,   8'd0,   8'd0));
    directed.push_back(make_cmd(OP_CREATE,  8'd0,   8'd1,   8'd0));
    directed.push_back(make_cmd(OP_CREATE,  8'd7,   8'd0,   8'd255));
    directed.push_back(make_cmd(OP_CREATE,  8'd3,   8'd255, 8'd1));
    directed.push_back(make_cmd(OP_CREATE,  8'd0,   8'd5,   8'd5));
    directed.push_back(make_cmd(OP_CREATE,  8'd8,   8'd2,   8'd2));
    directed.push_back(make_cmd(OP_CREATE,  8'd255, 8'd255, 8'd255));
    directed.push_back(make_cmd(OP_DELETE,  8'd5,   8'd0,   8'd0));
    directed.push_back(make_cmd(OP_SUSPEND, 8'd5,   8'd0,   8'd0));
    directed.push_back(make_cmd(OP_RESUME,  8'd5,   8'd0,   8'd0));
    directed.push_back(make_cmd(OP_TICK,    8'd0,   8'd0,   8'd0));
    directed.push_back(make_cmd(OP_TICK,    8'd255, 8'd255, 8'd255));
    directed.push_back(make_cmd(OP_SUSPEND, 8'd0,   8'd0,   8'd0));
    directed.push_back(make_cmd(OP_SUSPEND, 8'd0,   8'd0,   8'd0));
    directed.push_back(make_cmd(OP_TICK,    8'd0,   8'd0,   8'd0));
    directed.push_back(make_cmd(OP_RESUME,  8'd0,   8'd0,   8'd0));
    directed.push_back(make_cmd(OP_RESUME,  8'd0,   8'd0,   8'd0));
    directed.push_back(make_cmd(OP_TICK,    8'd0,   8'd0,   8'd0));
    directed.push_back(make_cmd(OP_DELETE,  8'd255, 8'd0,   8'd0));
    directed.push_back(make_cmd(OP_SUSPEND, 8'd200, 8'd0,   8'd0));
    directed.push_back(make_cmd(OP_RESUME,  8'd8,   8'd0,   8'd0));
    directed.push_back(make_cmd(3'd5,       8'd0,   8'd255, 8'd0));
    directed.push_back(make_cmd(3'd6,       8'd1,   8'd0,   8'd255));
    directed.push_back(make_cmd(3'd7,       8'd255, 8'd255, 8'd255));
    directed.push_back(make_cmd(OP_DELETE,  8'd7,   8'd0,   8'd0));

    sent = 0;
    foreach (directed[i]) begin
      send_command(directed[i]);
      sent++;
    end
    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (sent == HOLD_AT_ITEM) hold_req = 1'b1;
      no_idle = (sent >= CALM_FIRST && sent < CALM_LAST);
      send_command(random_cmd());
      sent++;
    end
    in_tvalid <= 1'b0;
    no_idle = 1'b0;

    // let the monitor note the last beat first; the watchdog
    // covers a hung output
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("periodic_task_release_scheduler regression: pass");
    end else begin
      $display("periodic_task_release_scheduler regression: fail");
    end
    $finish;
  end

endmodule
